@@ hw/rtl/dllc_pkg.sv @@
// Shared types and codes for the linked-list-with-cursor block.
// No dependencies; imported by the control and datapath modules.
`default_nettype none
package dllc_pkg;

    typedef enum logic [3:0] {
        ACT_FIRST      = 4'd0,
        ACT_NEXT       = 4'd1,
        ACT_LAST       = 4'd2,
        ACT_PREV       = 4'd3,
        ACT_PUSH_FRONT = 4'd4,
        ACT_PUSH_BACK  = 4'd5,
        ACT_PUSH_AFTER = 4'd6,
        ACT_POP_FRONT  = 4'd7,
        ACT_POP_BACK   = 4'd8,
        ACT_POP_CUR    = 4'd9,
        ACT_CLEAR      = 4'd10
    } t_action;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_NONE = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_STEP,
        S_PUSH_B,
        S_PUSH_C,
        S_POP_B,
        S_FIN
    } t_state;

    // Datapath micro-operations
    typedef enum logic [3:0] {
        UOP_NOP,
        UOP_CUR_NIL,
        UOP_RD_VAL,
        UOP_RD_NEXT,
        UOP_RD_PREV,
        UOP_STEP_NEXT,
        UOP_STEP_PREV,
        UOP_PUSH_A,
        UOP_PUSH_B,
        UOP_PUSH_C,
        UOP_POP_A,
        UOP_POP_B,
        UOP_CLEAR
    } t_uop;

    // Which list pointer a micro-op works on
    typedef enum logic [1:0] {
        SEL_NIL,
        SEL_HEAD,
        SEL_TAIL,
        SEL_CUR
    } t_sel;

    typedef struct packed {
        t_uop    uop;
        t_sel    sel;
        logic    set_cur;
        logic    load;
        logic    fin;
        logic    sel_val;
        t_status status;
    } t_cmd;

    typedef struct packed {
        logic head_nil;
        logic tail_nil;
        logic cur_nil;
        logic free_nil;
        logic nxt_nil;
        logic prv_nil;
        logic out_busy;
    } t_stat;

endpackage
`default_nettype wire

@@ hw/rtl/dllc_if.sv @@
// Request and response channel interfaces (valid/ready with payload).
// No dependencies.
`default_nettype none
interface dllc_req_if #(parameter int VALUE_WIDTH = 32);
    logic                   valid;
    logic                   ready;
    logic [3:0]             action;
    logic [VALUE_WIDTH-1:0] new_value;
    modport source (output valid, output action, output new_value, input ready);
    modport sink   (input valid, input action, input new_value, output ready);
endinterface

interface dllc_rsp_if #(parameter int VALUE_WIDTH = 32);
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] value_out;
    logic [1:0]             status;
    modport source (output valid, output value_out, output status, input ready);
    modport sink   (input valid, input value_out, input status, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/dllc_ctrl.sv @@
// Controller FSM: decodes the request action and sequences datapath micro-ops.
// Depends on dllc_pkg.
`default_nettype none
module dllc_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire logic [3:0]     i_action,
    output logic                o_ready,
    input  wire dllc_pkg::t_stat i_stat,
    output dllc_pkg::t_cmd      o_cmd
);
    import dllc_pkg::*;

    t_state  r_state, n_state;
    t_action r_act, n_act;
    t_status r_status, n_status;
    logic    r_sel_val, n_sel_val;
    logic    w_accept;

    assign w_accept = i_valid && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_act     <= n_act;
        r_status  <= n_status;
        r_sel_val <= n_sel_val;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_FIN;
                case (r_act)
                    ACT_NEXT, ACT_PREV: begin
                        if (!(i_stat.head_nil || i_stat.tail_nil || i_stat.cur_nil))
                            n_state = S_STEP;
                    end
                    ACT_PUSH_FRONT, ACT_PUSH_BACK, ACT_PUSH_AFTER: begin
                        if (!i_stat.free_nil) n_state = S_PUSH_B;
                    end
                    ACT_POP_FRONT: begin
                        if (!i_stat.head_nil) n_state = S_POP_B;
                    end
                    ACT_POP_BACK: begin
                        if (!i_stat.tail_nil) n_state = S_POP_B;
                    end
                    ACT_POP_CUR: begin
                        if (!i_stat.cur_nil) n_state = S_POP_B;
                    end
                    default: n_state = S_FIN;
                endcase
            end
            S_STEP:   n_state = S_FIN;
            S_PUSH_B: n_state = S_PUSH_C;
            S_PUSH_C: n_state = S_FIN;
            S_POP_B:  n_state = S_FIN;
            S_FIN: begin
                if (!i_stat.out_busy) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd         = '0;
        o_cmd.uop     = UOP_NOP;
        o_cmd.sel     = SEL_NIL;
        o_cmd.status  = r_status;
        o_cmd.sel_val = r_sel_val;
        o_ready       = 1'b0;
        n_act         = r_act;
        n_status      = r_status;
        n_sel_val     = r_sel_val;
        case (r_state)
            S_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = w_accept;
                if (w_accept) n_act = t_action'(i_action);
            end
            S_EXEC: begin
                n_status  = ST_DONE;
                n_sel_val = 1'b0;
                case (r_act)
                    ACT_FIRST, ACT_LAST: begin
                        if (i_stat.head_nil) begin
                            o_cmd.uop = UOP_CUR_NIL;
                            n_status  = ST_NONE;
                        end else begin
                            o_cmd.uop = UOP_RD_VAL;
                            o_cmd.sel = (r_act == ACT_FIRST) ? SEL_HEAD : SEL_TAIL;
                            n_sel_val = 1'b1;
                        end
                    end
                    ACT_NEXT, ACT_PREV: begin
                        if (i_stat.head_nil || i_stat.tail_nil || i_stat.cur_nil) begin
                            o_cmd.uop = UOP_CUR_NIL;
                            n_status  = ST_NONE;
                        end else begin
                            o_cmd.uop = (r_act == ACT_NEXT) ? UOP_RD_NEXT : UOP_RD_PREV;
                        end
                    end
                    ACT_PUSH_FRONT, ACT_PUSH_BACK, ACT_PUSH_AFTER: begin
                        if (i_stat.free_nil) begin
                            n_status = ST_FULL;
                        end else begin
                            o_cmd.uop = UOP_PUSH_A;
                            case (r_act)
                                ACT_PUSH_BACK:  o_cmd.sel = SEL_TAIL;
                                ACT_PUSH_AFTER: o_cmd.sel = SEL_CUR;
                                default:        o_cmd.sel = SEL_NIL;
                            endcase
                        end
                    end
                    ACT_POP_FRONT, ACT_POP_BACK, ACT_POP_CUR: begin
                        if ((r_act == ACT_POP_FRONT && i_stat.head_nil) ||
                            (r_act == ACT_POP_BACK  && i_stat.tail_nil) ||
                            (r_act == ACT_POP_CUR   && i_stat.cur_nil)) begin
                            o_cmd.uop = UOP_CUR_NIL;
                            n_status  = ST_NONE;
                        end else begin
                            o_cmd.uop = UOP_POP_A;
                            n_sel_val = 1'b1;
                            case (r_act)
                                ACT_POP_FRONT: o_cmd.sel = SEL_HEAD;
                                ACT_POP_BACK:  o_cmd.sel = SEL_TAIL;
                                default:       o_cmd.sel = SEL_CUR;
                            endcase
                        end
                    end
                    ACT_CLEAR: o_cmd.uop = UOP_CLEAR;
                    default:   n_status  = ST_NONE;
                endcase
            end
            S_STEP: begin
                if ((r_act == ACT_NEXT) ? i_stat.nxt_nil : i_stat.prv_nil) begin
                    o_cmd.uop = UOP_CUR_NIL;
                    n_status  = ST_NONE;
                end else begin
                    o_cmd.uop = (r_act == ACT_NEXT) ? UOP_STEP_NEXT : UOP_STEP_PREV;
                    n_sel_val = 1'b1;
                end
            end
            S_PUSH_B: o_cmd.uop = UOP_PUSH_B;
            S_PUSH_C: begin
                o_cmd.uop     = UOP_PUSH_C;
                o_cmd.set_cur = (r_act != ACT_PUSH_FRONT);
            end
            S_POP_B: o_cmd.uop = UOP_POP_B;
            S_FIN:   o_cmd.fin = !i_stat.out_busy;
            default: o_cmd.uop = UOP_NOP;
        endcase
    end

endmodule
`default_nettype wire

@@ hw/rtl/dllc_dpath.sv @@
// Datapath: node pool memories, list pointers, free chain and response register.
// Depends on dllc_pkg.
`default_nettype none
module dllc_dpath #(
    parameter int NODE_COUNT  = 256,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire dllc_pkg::t_cmd         i_cmd,
    input  wire logic [VALUE_WIDTH-1:0] i_new_value,
    output dllc_pkg::t_stat             o_stat,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic [VALUE_WIDTH-1:0]      o_value_out,
    output logic [1:0]                  o_status
);
    import dllc_pkg::*;

    localparam int IW = $clog2(NODE_COUNT + 1);
    localparam int AW = $clog2(NODE_COUNT);
    localparam logic [IW-1:0] NIL = IW'(NODE_COUNT);

    logic [VALUE_WIDTH-1:0] mem_val [NODE_COUNT];
    logic [IW-1:0]          mem_nxt [NODE_COUNT];
    logic [IW-1:0]          mem_prv [NODE_COUNT];

    logic [IW-1:0] r_head, n_head, r_tail, n_tail, r_cur, n_cur;
    logic [IW-1:0] r_free, n_free, r_fill, n_fill;
    logic [IW-1:0] r_n, n_n, r_p, n_p, r_nx, n_nx;
    logic [VALUE_WIDTH-1:0] r_val_in, r_val_q;
    logic [IW-1:0] r_nxt_q, r_nxt_alt, r_prv_q;
    logic          r_nxt_fresh;
    logic          r_ovalid;
    logic [VALUE_WIDTH-1:0] r_oval;
    logic [1:0]    r_ost;

    logic          vl_re, vl_we, nx_re, nx_we, pv_re, pv_we;
    logic [IW-1:0] vl_ra, vl_wa, nx_ra, nx_wa, nx_wd, pv_ra, pv_wa, pv_wd;
    logic [IW-1:0] w_sel, w_nxt, w_push_nx;

    // nodes at or above the fill mark were never allocated: implicit link to i+1
    assign w_nxt = r_nxt_fresh ? r_nxt_alt : r_nxt_q;

    always_comb begin
        case (i_cmd.sel)
            SEL_HEAD: w_sel = r_head;
            SEL_TAIL: w_sel = r_tail;
            SEL_CUR:  w_sel = r_cur;
            default:  w_sel = NIL;
        endcase
    end

    assign w_push_nx = (r_p != NIL) ? w_nxt : r_nx;

    always_comb begin
        n_head = r_head; n_tail = r_tail; n_cur = r_cur;
        n_free = r_free; n_fill = r_fill;
        n_n = r_n; n_p = r_p; n_nx = r_nx;
        vl_re = 1'b0; vl_we = 1'b0; nx_re = 1'b0; nx_we = 1'b0;
        pv_re = 1'b0; pv_we = 1'b0;
        vl_ra = w_sel; vl_wa = r_free;
        nx_ra = w_sel; nx_wa = r_n; nx_wd = r_n;
        pv_ra = r_cur; pv_wa = r_free; pv_wd = w_sel;
        case (i_cmd.uop)
            UOP_CUR_NIL: n_cur = NIL;
            UOP_RD_VAL: begin
                n_cur = w_sel;
                vl_re = 1'b1;
            end
            UOP_RD_NEXT: begin
                nx_re = 1'b1;
                nx_ra = r_cur;
            end
            UOP_RD_PREV: pv_re = 1'b1;
            UOP_STEP_NEXT: begin
                n_cur = w_nxt;
                vl_re = 1'b1;
                vl_ra = w_nxt;
            end
            UOP_STEP_PREV: begin
                n_cur = r_prv_q;
                vl_re = 1'b1;
                vl_ra = r_prv_q;
            end
            UOP_PUSH_A: begin
                n_n   = r_free;
                n_p   = w_sel;
                n_nx  = r_head;
                vl_we = 1'b1;
                pv_we = 1'b1;
                nx_re = 1'b1;
                nx_ra = r_free;
                if (r_free == r_fill) n_fill = r_fill + 1'b1;
            end
            UOP_PUSH_B: begin
                n_free = w_nxt;
                if (r_p != NIL) begin
                    nx_re = 1'b1;
                    nx_ra = r_p;
                    nx_we = 1'b1;
                    nx_wa = r_p;
                    nx_wd = r_n;
                end else begin
                    n_head = r_n;
                end
            end
            UOP_PUSH_C: begin
                nx_we = 1'b1;
                nx_wa = r_n;
                nx_wd = w_push_nx;
                if (w_push_nx != NIL) begin
                    pv_we = 1'b1;
                    pv_wa = w_push_nx;
                    pv_wd = r_n;
                end else begin
                    n_tail = r_n;
                end
                if (i_cmd.set_cur) n_cur = r_n;
            end
            UOP_POP_A: begin
                vl_re  = 1'b1;
                nx_re  = 1'b1;
                pv_re  = 1'b1;
                pv_ra  = w_sel;
                nx_we  = 1'b1;
                nx_wa  = w_sel;
                nx_wd  = r_free;
                n_free = w_sel;
            end
            UOP_POP_B: begin
                if (r_prv_q != NIL) begin
                    nx_we = 1'b1;
                    nx_wa = r_prv_q;
                    nx_wd = w_nxt;
                end else begin
                    n_head = w_nxt;
                end
                if (w_nxt != NIL) begin
                    pv_we = 1'b1;
                    pv_wa = w_nxt;
                    pv_wd = r_prv_q;
                end else begin
                    n_tail = r_prv_q;
                end
                n_cur = w_nxt;
            end
            UOP_CLEAR: begin
                if (r_head != NIL && r_tail != NIL) begin
                    nx_we  = 1'b1;
                    nx_wa  = r_tail;
                    nx_wd  = r_free;
                    n_free = r_head;
                end
                n_head = NIL;
                n_tail = NIL;
                n_cur  = NIL;
            end
            default: n_cur = r_cur;
        endcase
    end

    // memories, read-first
    always_ff @(posedge i_clk) begin
        if (vl_re) r_val_q <= mem_val[vl_ra[AW-1:0]];
        if (vl_we) mem_val[vl_wa[AW-1:0]] <= r_val_in;
        if (nx_re) begin
            r_nxt_q     <= mem_nxt[nx_ra[AW-1:0]];
            r_nxt_fresh <= (nx_ra >= r_fill);
            r_nxt_alt   <= nx_ra + 1'b1;
        end
        if (nx_we) mem_nxt[nx_wa[AW-1:0]] <= nx_wd;
        if (pv_re) r_prv_q <= mem_prv[pv_ra[AW-1:0]];
        if (pv_we) mem_prv[pv_wa[AW-1:0]] <= pv_wd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= NIL;
            r_tail   <= NIL;
            r_cur    <= NIL;
            r_free   <= '0;
            r_fill   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_cur  <= n_cur;
            r_free <= n_free;
            r_fill <= n_fill;
            if (i_cmd.fin) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
        end
        r_n  <= n_n;
        r_p  <= n_p;
        r_nx <= n_nx;
        if (i_cmd.load) r_val_in <= i_new_value;
        if (i_cmd.fin) begin
            r_oval <= i_cmd.sel_val ? r_val_q : '0;
            r_ost  <= i_cmd.status;
        end
    end

    assign o_valid     = r_ovalid;
    assign o_value_out = r_oval;
    assign o_status    = r_ost;

    assign o_stat.head_nil = (r_head == NIL);
    assign o_stat.tail_nil = (r_tail == NIL);
    assign o_stat.cur_nil  = (r_cur == NIL);
    assign o_stat.free_nil = (r_free == NIL);
    assign o_stat.nxt_nil  = (w_nxt == NIL);
    assign o_stat.prv_nil  = (r_prv_q == NIL);
    assign o_stat.out_busy = r_ovalid && !i_ready;

endmodule
`default_nettype wire

@@ hw/rtl/doubly_linked_list_with_cursor.sv @@
// Top level of the doubly linked list with cursor: controller plus datapath.
// Depends on dllc_pkg, dllc_if, dllc_ctrl and dllc_dpath.
`default_nettype none
// Keeps a doubly linked list of data words in a pool of NODE_COUNT nodes, with
// head, tail, cursor and a free chain. One request carries one action (moves,
// pushes, pops, clear) and gives exactly one response with a value and a
// status. Requests are handled one at a time. Clear, first/last, refused
// pushes and moves or pops that find no node go from S_EXEC straight to
// S_FIN; next/prev add the S_STEP state, pops the S_POP_B state and pushes
// the S_PUSH_B and S_PUSH_C states, as the single write port of the
// next-link memory is touched by a push on two different nodes. The
// controller then returns to idle before the next request is taken. The
// response sits in an output register, so a new request is taken while the
// last response waits. No clearing pass after reset: never-allocated nodes
// are tracked by a fill mark and link implicitly to the next index.
module doubly_linked_list_with_cursor #(
    parameter int NODE_COUNT  = 256,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    dllc_req_if.sink    i_req,
    dllc_rsp_if.source  o_rsp
);
    import dllc_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    // control: action decode and micro-op sequencing
    dllc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_req.valid),
        .i_action (i_req.action),
        .o_ready  (i_req.ready),
        .i_stat   (w_stat),
        .o_cmd    (w_cmd)
    );

    // storage, pointers and response register
    dllc_dpath #(
        .NODE_COUNT  (NODE_COUNT),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_new_value (i_req.new_value),
        .o_stat      (w_stat),
        .o_valid     (o_rsp.valid),
        .i_ready     (o_rsp.ready),
        .o_value_out (o_rsp.value_out),
        .o_status    (o_rsp.status)
    );

    // one request in flight: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request accepted while another is in progress");

    // a response appears only when the controller finished a request
    a_rsp_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !$past(o_rsp.valid)) |-> $past(w_cmd.fin))
        else $error("response without a finished request");

    // full status only when the free chain is really empty
    a_full_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.fin && w_cmd.status == ST_FULL) |-> w_stat.free_nil)
        else $error("full reported with free nodes left");

endmodule
`default_nettype wire
